@@ rtl/tab_pkg.sv @@
`default_nettype none

package tab_pkg;

   // Pipeline depth: product, blend product, sum, remainder, correction.
   localparam int NumStages = 5;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 8;

   localparam logic [CsrIndexWidth-1:0] CsrTintRed   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrTintGreen = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrTintBlue  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrTintAlpha = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrStampMode = 3'd4;

   localparam logic [7:0]  Full8  = 8'd255;
   localparam logic [15:0] Full16 = 16'd65025;
   localparam logic [31:0] Full24 = 32'd16581375;

   // Multiples of 255^3 for the quotient correction step.
   localparam int RemWidth = 26;
   localparam logic [RemWidth-1:0] Full24x1 = 26'd16581375;
   localparam logic [RemWidth-1:0] Full24x2 = 26'd33162750;
   localparam logic [RemWidth-1:0] Full24x3 = 26'd49744125;

   typedef logic [NumStages-1:0] stage_en_type;

   typedef struct packed {
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
      logic [7:0] src_alpha;
      logic [7:0] dst_red;
      logic [7:0] dst_green;
      logic [7:0] dst_blue;
      logic [7:0] dst_alpha;
   } req_pixel_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_pixel_type;

   typedef struct packed {
      logic [7:0] tint_red;
      logic [7:0] tint_green;
      logic [7:0] tint_blue;
      logic [7:0] tint_alpha;
      logic       stamp_mode;
   } cfg_type;

   // Exact floor(x / 255) for x up to 255 * 255.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [15:0] sum;
      sum = x + 16'(x[15:8]) + 16'd1;
      return sum[15:8];
   endfunction

endpackage

`default_nettype wire

@@ rtl/tab_csr.sv @@
`default_nettype none

module tab_csr
   import tab_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_data,
   output cfg_type                       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CsrTintRed:   cfg_in.tint_red   = csr_data;
            CsrTintGreen: cfg_in.tint_green = csr_data;
            CsrTintBlue:  cfg_in.tint_blue  = csr_data;
            CsrTintAlpha: cfg_in.tint_alpha = csr_data;
            CsrStampMode: cfg_in.stamp_mode = csr_data[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tint_red   <= Full8;
         cfg_ff.tint_green <= Full8;
         cfg_ff.tint_blue  <= Full8;
         cfg_ff.tint_alpha <= Full8;
         cfg_ff.stamp_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/tab_chan.sv @@
`default_nettype none

// One color channel: c = (255*d*(65025 - sA) + t*s*sA) / 255^3.
// All four tint modes reduce exactly to this form.
module tab_chan
   import tab_pkg::*;
(
   input  wire logic         clock,
   input  wire stage_en_type en,
   input  wire logic [7:0]   chan_s,
   input  wire logic [7:0]   chan_d,
   input  wire logic [7:0]   chan_t,
   input  wire logic [15:0]  sa_ta,
   input  wire logic         copy,
   output logic [7:0]        chan_out
);

   logic [15:0]         ts_ff, ts_in;
   logic [15:0]         d255_ff, d255_in;
   logic [7:0]          s1_ff, s2_ff, s3_ff, s4_ff;
   logic [31:0]         p1_ff, p1_in;
   logic [31:0]         p2_ff, p2_in;
   logic [31:0]         num_ff, num_in;
   logic [7:0]          q0_ff;
   logic [RemWidth-1:0] rem_ff, rem_in;
   logic [7:0]          out_ff, out_in;

   always_comb begin
      ts_in   = 16'(chan_t) * 16'(chan_s);
      d255_in = 16'({chan_d, 8'h00}) - 16'(chan_d);
      p1_in   = 32'(d255_ff) * 32'(Full16 - sa_ta);
      p2_in   = 32'(ts_ff) * 32'(sa_ta);
      num_in  = p1_ff + p2_ff;
      // The top byte undershoots the quotient by at most three.
      rem_in  = RemWidth'(num_ff - 32'(num_ff[31:24]) * Full24);
      out_in  = q0_ff + 8'(rem_ff >= Full24x1) + 8'(rem_ff >= Full24x2)
                      + 8'(rem_ff >= Full24x3);
      if (copy) begin
         out_in = s4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ts_ff   <= ts_in;
         d255_ff <= d255_in;
         s1_ff   <= chan_s;
      end
      if (en[1]) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         s2_ff <= s1_ff;
      end
      if (en[2]) begin
         num_ff <= num_in;
         s3_ff  <= s2_ff;
      end
      if (en[3]) begin
         q0_ff  <= num_ff[31:24];
         rem_ff <= rem_in;
         s4_ff  <= s3_ff;
      end
      if (en[4]) begin
         out_ff <= out_in;
      end
   end

   assign chan_out = out_ff;

endmodule

`default_nettype wire

@@ rtl/tinted_alpha_blend.sv @@
`default_nettype none

// Tinted alpha blend of one RGBA8 source pixel over one RGBA8 destination
// pixel. The block is a five-stage pipeline that takes one pixel word per
// clock and returns each blended word from its last stage; a full pipeline
// keeps that rate as long as the result side takes a word each cycle. A
// stall on the result side holds the waiting word and every full stage
// behind it, while empty stages still take the words in front of them. The
// tint color,
// global alpha and stamp mode live in five registers written through the
// csr port (0 red, 1 green, 2 blue, 3 alpha, 4 stamp mode in bit 0; other
// indexes are ignored), and should only be changed while no pixel is in
// flight. Color division by 255, 255^2 or 255^3 truncates.
module tinted_alpha_blend
   import tab_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_pixel_type            req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_pixel_type                 rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_data
);

   cfg_type      cfg;
   stage_en_type en;
   logic [NumStages-1:0] valid_ff;

   logic [15:0] sa_ta_ff, sa_ta_in;
   logic [7:0]  da1_ff, da2_ff;
   logic [7:0]  al2_ff;
   logic [7:0]  oa3_ff, oa4_ff, oa5_ff, oa3_in;
   logic        cp3_ff, cp4_ff, cp3_in;
   logic        rgb_white;
   logic [7:0]  red_out, green_out, blue_out;

   assign csr_ready = 1'b1;

   tab_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // A stage loads when it is empty or the stage after it moves on.
   always_comb begin
      en[NumStages-1] = !valid_ff[NumStages-1] || rsp_ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NumStages; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // Alpha path. In stamp mode the merged alpha is max(sA/255, dst alpha)
   // in every tint mode; with a white RGB tint and an empty destination
   // the source color is copied unblended.
   always_comb begin
      sa_ta_in  = 16'(req_data.src_alpha) * 16'(cfg.tint_alpha);
      rgb_white = (cfg.tint_red == Full8) && (cfg.tint_green == Full8)
                  && (cfg.tint_blue == Full8);
      oa3_in    = da2_ff;
      if (cfg.stamp_mode && (al2_ff > da2_ff)) begin
         oa3_in = al2_ff;
      end
      cp3_in = cfg.stamp_mode && rgb_white && (da2_ff == 8'd0);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sa_ta_ff <= sa_ta_in;
         da1_ff   <= req_data.dst_alpha;
      end
      if (en[1]) begin
         al2_ff <= div255(sa_ta_ff);
         da2_ff <= da1_ff;
      end
      if (en[2]) begin
         oa3_ff <= oa3_in;
         cp3_ff <= cp3_in;
      end
      if (en[3]) begin
         oa4_ff <= oa3_ff;
         cp4_ff <= cp3_ff;
      end
      if (en[4]) begin
         oa5_ff <= oa4_ff;
      end
   end

   tab_chan u_red (
      .clock    (clock),
      .en       (en),
      .chan_s   (req_data.src_red),
      .chan_d   (req_data.dst_red),
      .chan_t   (cfg.tint_red),
      .sa_ta    (sa_ta_ff),
      .copy     (cp4_ff),
      .chan_out (red_out)
   );

   tab_chan u_green (
      .clock    (clock),
      .en       (en),
      .chan_s   (req_data.src_green),
      .chan_d   (req_data.dst_green),
      .chan_t   (cfg.tint_green),
      .sa_ta    (sa_ta_ff),
      .copy     (cp4_ff),
      .chan_out (green_out)
   );

   tab_chan u_blue (
      .clock    (clock),
      .en       (en),
      .chan_s   (req_data.src_blue),
      .chan_d   (req_data.dst_blue),
      .chan_t   (cfg.tint_blue),
      .sa_ta    (sa_ta_ff),
      .copy     (cp4_ff),
      .chan_out (blue_out)
   );

   assign rsp_valid          = valid_ff[NumStages-1];
   assign rsp_data.out_red   = red_out;
   assign rsp_data.out_green = green_out;
   assign rsp_data.out_blue  = blue_out;
   assign rsp_data.out_alpha = oa5_ff;

endmodule

`default_nettype wire

@@ test/tinted_alpha_blend_checker.sv @@
module tinted_alpha_blend_checker
   import tab_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire req_pixel_type            req_data,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire rsp_pixel_type            rsp_data,
   input  wire logic                     csr_valid,
   input  wire logic                     csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_data,
   output int                            fail_count,
   output int                            pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      ModeWhite,
      ModeWhiteRgb,
      ModeOpaqueTint,
      ModeGeneral
   } tint_mode_type;

   cfg_type       tint_shadow;
   rsp_pixel_type expected_pixels[$];
   rsp_pixel_type oldest;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic rsp_pixel_type blend_pixel(input req_pixel_type px, input cfg_type cf);
      logic [63:0]   s[3];
      logic [63:0]   d[3];
      logic [63:0]   t[3];
      logic [63:0]   c[3];
      logic [63:0]   sa;
      logic [63:0]   da;
      logic [63:0]   oa;
      logic [63:0]   sa_eff;
      logic          rgb_white;
      tint_mode_type mode;
      rsp_pixel_type r;
      s[0] = 64'(px.src_red);
      s[1] = 64'(px.src_green);
      s[2] = 64'(px.src_blue);
      d[0] = 64'(px.dst_red);
      d[1] = 64'(px.dst_green);
      d[2] = 64'(px.dst_blue);
      t[0] = 64'(cf.tint_red);
      t[1] = 64'(cf.tint_green);
      t[2] = 64'(cf.tint_blue);
      sa = 64'(px.src_alpha);
      da = 64'(px.dst_alpha);
      oa = da;
      sa_eff = sa * 64'(cf.tint_alpha);
      rgb_white = (cf.tint_red == Full8) && (cf.tint_green == Full8) &&
                  (cf.tint_blue == Full8);
      if (rgb_white && cf.tint_alpha == Full8) mode = ModeWhite;
      else if (rgb_white) mode = ModeWhiteRgb;
      else if (cf.tint_alpha == Full8) mode = ModeOpaqueTint;
      else mode = ModeGeneral;

      for (int i = 0; i < 3; i++) begin
         case (mode)
            ModeWhite: begin
               if (sa == Full8) c[i] = s[i];
               else c[i] = (d[i] * (Full8 - sa) + s[i] * sa) / Full8;
            end
            ModeWhiteRgb: begin
               c[i] = (d[i] * (Full16 - sa_eff) + s[i] * sa_eff) / Full16;
            end
            ModeOpaqueTint: begin
               if (sa == Full8) c[i] = (t[i] * s[i]) / Full8;
               else c[i] = (Full8 * d[i] * (Full8 - sa) + t[i] * s[i] * sa) / Full16;
            end
            default: begin
               c[i] = (Full8 * d[i] * (Full16 - sa_eff) + t[i] * s[i] * sa_eff) / Full24;
            end
         endcase
      end

      // Stamp merges alpha; in the white modes an empty destination takes the source.
      if (cf.stamp_mode) begin
         case (mode)
            ModeWhite: begin
               if (sa == Full8 || da == 0) begin
                  for (int i = 0; i < 3; i++) c[i] = s[i];
                  oa = sa;
               end else begin
                  oa = (sa > da) ? sa : da;
               end
            end
            ModeWhiteRgb: begin
               if (da == 0) begin
                  for (int i = 0; i < 3; i++) c[i] = s[i];
                  oa = sa_eff / Full8;
               end else begin
                  oa = (sa_eff / Full8 > da) ? sa_eff / Full8 : da;
               end
            end
            ModeOpaqueTint: begin
               oa = (sa > da) ? sa : da;
            end
            default: begin
               oa = (sa_eff / Full8 > da) ? sa_eff / Full8 : da;
            end
         endcase
      end

      r.out_red   = c[0][7:0];
      r.out_green = c[1][7:0];
      r.out_blue  = c[2][7:0];
      r.out_alpha = oa[7:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tint_shadow = '{tint_red: Full8, tint_green: Full8, tint_blue: Full8,
                         tint_alpha: Full8, stamp_mode: 1'b0};
         expected_pixels.delete();
      end else begin
         if (req_valid && req_ready) begin
            expected_pixels.push_back(blend_pixel(req_data, tint_shadow));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("result word with no expected pixel pending");
               fail_count++;
            end else begin
               oldest = expected_pixels.pop_front();
               check_field("out_red", oldest.out_red, rsp_data.out_red);
               check_field("out_green", oldest.out_green, rsp_data.out_green);
               check_field("out_blue", oldest.out_blue, rsp_data.out_blue);
               check_field("out_alpha", oldest.out_alpha, rsp_data.out_alpha);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrTintRed:   tint_shadow.tint_red   = csr_data;
               CsrTintGreen: tint_shadow.tint_green = csr_data;
               CsrTintBlue:  tint_shadow.tint_blue  = csr_data;
               CsrTintAlpha: tint_shadow.tint_alpha = csr_data;
               CsrStampMode: tint_shadow.stamp_mode = csr_data[0];
               default: ;
            endcase
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

@@ test/tinted_alpha_blend_tb.sv @@
module tinted_alpha_blend_tb
   import tab_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 2000;
   localparam int HoldCycles    = 60;
   localparam int NumPhases     = 16;
   localparam int PixelsPerPhase = 50;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_pixel_type            req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_pixel_type            rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_data;

   int fail_count;
   int pending_count;
   int snd_idle;
   int rcv_idle;
   bit hold_pending;
   int quiet_cycles;

   tinted_alpha_blend u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   tinted_alpha_blend_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready = 1'b0;
            repeat (HoldCycles - 1) @(negedge clock);
         end else begin
            rsp_ready = ($urandom_range(99) >= rcv_idle);
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WatchdogLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("tinted_alpha_blend test failed");
      $finish;
   end

   function automatic logic [7:0] edge_byte();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return Full8;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic req_pixel_type random_pixel();
      req_pixel_type px;
      px = req_pixel_type'($urandom);
      px[63:32] = $urandom;
      px.src_alpha = edge_byte();
      px.dst_alpha = edge_byte();
      if ($urandom_range(7) == 0) begin
         px.src_red = edge_byte();
         px.dst_blue = edge_byte();
      end
      return px;
   endfunction

   // All tasks below start and end at a falling edge.
   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx, input logic [7:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic apply_tint(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic [7:0] alpha,
                             input logic stamp);
      write_reg(CsrTintRed, red);
      write_reg(CsrTintGreen, green);
      write_reg(CsrTintBlue, blue);
      write_reg(CsrTintAlpha, alpha);
      // Upper bits of the stamp word are junk and must be dropped.
      write_reg(CsrStampMode, {7'($urandom), stamp});
      for (int k = int'(CsrStampMode) + 1; k < (1 << CsrIndexWidth); k++) begin
         write_reg(CsrIndexWidth'(k), 8'($urandom));
      end
   endtask

   task automatic send_pixel(input req_pixel_type px);
      while ($urandom_range(99) < snd_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (NumStages + 2) @(negedge clock);
   endtask

   initial begin
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      snd_idle     = 29;
      rcv_idle     = 77;
      hold_pending = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset tint is plain white paint.
      send_pixel(req_pixel_type'({8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255}));
      send_pixel(req_pixel_type'({8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0}));
      send_pixel(req_pixel_type'({8'd200, 8'd100, 8'd50, 8'd128, 8'd10, 8'd20, 8'd30, 8'd40}));
      drain();
      apply_tint(Full8, Full8, Full8, Full8, 1'b1);
      send_pixel(req_pixel_type'({8'd1, 8'd2, 8'd3, 8'd255, 8'd100, 8'd100, 8'd100, 8'd100}));
      send_pixel(req_pixel_type'({8'd90, 8'd80, 8'd70, 8'd60, 8'd1, 8'd2, 8'd3, 8'd0}));
      send_pixel(req_pixel_type'({8'd90, 8'd80, 8'd70, 8'd60, 8'd1, 8'd2, 8'd3, 8'd200}));
      drain();
      apply_tint(Full8, Full8, Full8, 8'd128, 1'b1);
      send_pixel(req_pixel_type'({8'd250, 8'd5, 8'd128, 8'd200, 8'd7, 8'd8, 8'd9, 8'd0}));
      send_pixel(req_pixel_type'({8'd250, 8'd5, 8'd128, 8'd200, 8'd7, 8'd8, 8'd9, 8'd100}));
      send_pixel(req_pixel_type'({8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255}));
      drain();
      apply_tint(8'd0, 8'd128, Full8, Full8, 1'b1);
      send_pixel(req_pixel_type'({8'd255, 8'd255, 8'd255, 8'd255, 8'd9, 8'd9, 8'd9, 8'd9}));
      send_pixel(req_pixel_type'({8'd255, 8'd255, 8'd255, 8'd0, 8'd9, 8'd9, 8'd9, 8'd9}));
      send_pixel(req_pixel_type'({8'd200, 8'd200, 8'd200, 8'd100, 8'd50, 8'd50, 8'd50, 8'd150}));
      drain();
      apply_tint(8'd10, 8'd20, 8'd30, 8'd0, 1'b0);
      send_pixel(req_pixel_type'({8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}));
      send_pixel(req_pixel_type'({8'd128, 8'd64, 8'd32, 8'd16, 8'd8, 8'd4, 8'd2, 8'd1}));
      drain();
      apply_tint(Full8, 8'd0, Full8, 8'd254, 1'b1);
      send_pixel(req_pixel_type'({8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0}));
      send_pixel(req_pixel_type'({8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255}));
      drain();

      // Each phase walks one tint mode in paint or stamp.
      for (int phase = 0; phase < NumPhases; phase++) begin
         red   = Full8;
         green = Full8;
         blue  = Full8;
         alpha = Full8;
         if (phase % 4 == 1 || phase % 4 == 3) begin
            alpha = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(254));
         end
         if (phase % 4 >= 2) begin
            red   = edge_byte();
            green = edge_byte();
            blue  = edge_byte();
            if (red == Full8 && green == Full8 && blue == Full8) begin
               red = 8'($urandom_range(254));
            end
         end
         apply_tint(red, green, blue, alpha, 1'((phase / 4) % 2));

         if (phase < 6) begin
            snd_idle = 29;
            rcv_idle = 77;
         end else if (phase < 11) begin
            snd_idle = 77;
            rcv_idle = 29;
         end else begin
            snd_idle = 0;
            rcv_idle = 0;
         end
         if (phase == 2 || phase == 12) hold_pending = 1'b1;

         for (int n = 0; n < PixelsPerPhase; n++) begin
            send_pixel(random_pixel());
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("tinted_alpha_blend test passed");
      end else begin
         $display("tinted_alpha_blend test failed");
      end
      $finish;
   end

endmodule

@@ tinted_alpha_blend.f @@
rtl/tab_pkg.sv
rtl/tab_csr.sv
rtl/tab_chan.sv
rtl/tinted_alpha_blend.sv
test/tinted_alpha_blend_checker.sv
test/tinted_alpha_blend_tb.sv
